// ----- hdl/assert_macros.svh -----
// Assertion macros for the RTL of the key press edge tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent on one clock edge implies consequent on the same edge.
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent on one clock edge implies consequent on the next edge.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/kpet_pkg.sv -----
// Shared types and constants for the key press edge tracker.
`timescale 1ns / 1ps
`default_nettype none

package kpet_pkg;

    // Default number of tracked keys
    localparam int KEYS_DEFAULT = 128;

    // Port field widths
    localparam int MODE_W  = 2;
    localparam int KEY_W   = 7;
    localparam int SDATA_W = 8;
    localparam int MDATA_W = 8;

    // Item kinds carried on s_tuser
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK    = 2'd0,
        MODE_PRESS   = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_QUERY   = 2'd3
    } mode_t;

    // Per-key status word: bit 0 held now, bit 1 event this frame, bit 2 held last frame
    typedef struct packed {
        logic held_prev;
        logic event_now;
        logic held;
    } status_t;

    // Result beat fields, highest bit first in the packed layout
    typedef struct packed {
        logic released_edge;
        logic pressed_repeated;
        logic pressed_edge;
        logic pressed;
    } result_t;

    // Status after a frame tick: held carried into held-last-frame, event cleared
    function automatic status_t age_status(input status_t s);
        status_t a;
        a.held_prev = s.held;
        a.event_now = 1'b0;
        a.held      = s.held;
        return a;
    endfunction

    // Derive the reported flags from a status word
    function automatic result_t status_to_result(input status_t s);
        result_t r;
        r.pressed          = s.held;
        r.pressed_edge     = s.held & ~s.held_prev;
        r.pressed_repeated = s.held & s.event_now;
        r.released_edge    = ~s.held & s.held_prev;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/key_press_edge_tracker_core.sv -----
// Top level of the key press edge tracker: status memory, update logic and result register.
`timescale 1ns / 1ps
`default_nettype none

// Tracks held / event / held-last-frame for KEYS keys. Each input beat carries a kind on
// s_tuser (tick, press, release, query) and a key index on s_tdata; each returns one result
// beat with the named key's flags after the update. One beat is taken per clock cycle while
// the result register is not stalled. The accepting edge loads the input stage and does the
// registered read of the status memory; the result register is loaded from the update
// logic when the input stage drains. A tick ages all keys at once by clearing a per-key
// "written this frame" bit; keys not written since the last tick read back in aged form.
// The status memory itself is not cleared: a per-key flip-flop marks entries never written
// since reset, so the block is ready right after reset. Key indexes at or above KEYS report
// all flags low, and press or release beats with such an index change nothing.
module key_press_edge_tracker_core #(
    parameter int KEYS = kpet_pkg::KEYS_DEFAULT
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // s_tdata: [6:0] key_index, [7] zero
    input  wire logic [kpet_pkg::SDATA_W-1:0] s_tdata,
    // s_tuser: [1:0] mode
    input  wire logic [kpet_pkg::MODE_W-1:0]  s_tuser,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // m_tdata: [0] pressed, [1] pressed_edge, [2] pressed_repeated, [3] released_edge,
    //          [7:4] zero
    output logic [kpet_pkg::MDATA_W-1:0]      m_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready
);
    import kpet_pkg::*;

    `include "assert_macros.svh"

    // Address width of the status memory
    localparam int AW = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam logic [8:0] KEYS_LIM = 9'(KEYS);

    // Status memory
    status_t key_mem [KEYS];

    // Per-key flags: entry written since reset, entry written in current frame
    logic [KEYS-1:0] written_reg;
    logic [KEYS-1:0] fresh_reg;

    // Input stage
    logic          p_valid_reg;
    mode_t         p_mode_reg;
    logic [7:0]    p_key_reg;
    status_t       rd_raw_reg;
    logic          byp_reg;
    status_t       byp_data_reg;

    // Output stage
    logic          m_valid_reg;
    result_t       m_res_reg;

    // Handshake and update signals
    logic          advance;
    logic          s_fire;
    logic          proc;
    logic [7:0]    s_key;
    logic [AW-1:0] s_addr;
    logic [AW-1:0] p_addr;
    logic          p_ok;
    status_t       raw;
    status_t       eff;
    status_t       upd;
    logic          wr_en;
    result_t       res_next;

    // Flow control: the input stage drains whenever the result register can take a beat
    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance || !p_valid_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign proc     = p_valid_reg && advance;

    assign s_key  = {1'b0, s_tdata[KEY_W-1:0]};
    assign s_addr = s_key[AW-1:0];
    assign p_addr = p_key_reg[AW-1:0];
    assign p_ok   = {1'b0, p_key_reg} < KEYS_LIM;

    // Read data, forwarded when the previous beat wrote the same key
    assign raw = byp_reg ? byp_data_reg : rd_raw_reg;

    // Effective status and update for the beat in the input stage
    always_comb begin
        if (!written_reg[p_addr]) begin
            eff = '0;
        end else if (!fresh_reg[p_addr]) begin
            eff = age_status(raw);
        end else begin
            eff = raw;
        end
        upd   = eff;
        wr_en = 1'b0;
        unique case (p_mode_reg)
            MODE_TICK: begin
                upd = age_status(eff);
            end
            MODE_PRESS: begin
                upd.held      = 1'b1;
                upd.event_now = 1'b1;
                wr_en         = p_ok;
            end
            MODE_RELEASE: begin
                upd.held      = 1'b0;
                upd.event_now = 1'b1;
                wr_en         = p_ok;
            end
            MODE_QUERY: begin
                upd = eff;
            end
            default: begin
                upd = eff;
            end
        endcase
        res_next = p_ok ? status_to_result(upd) : '0;
    end

    // Status memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (proc && wr_en) begin
            key_mem[p_addr] <= upd;
        end
        if (s_fire) begin
            rd_raw_reg   <= key_mem[s_addr];
            byp_reg      <= proc && wr_en && (p_key_reg == s_key);
            byp_data_reg <= upd;
        end
    end

    // Per-key flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
            fresh_reg   <= '0;
        end else if (proc) begin
            if (p_mode_reg == MODE_TICK) begin
                fresh_reg <= '0;
            end else if (wr_en) begin
                written_reg[p_addr] <= 1'b1;
                fresh_reg[p_addr]   <= 1'b1;
            end
        end
    end

    // Input stage control and payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (s_fire) begin
            p_valid_reg <= 1'b1;
        end else if (proc) begin
            p_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p_mode_reg <= mode_t'(s_tuser);
            p_key_reg  <= s_key;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            m_res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(MDATA_W - 4){1'b0}}, m_res_reg};

    // A beat leaving the input stage always lands in the result register
    `ASSERT_NEXT(a_proc_to_out, aclk, aresetn, proc, m_valid_reg)
    // A tick leaves no key marked as written this frame
    `ASSERT_NEXT(a_tick_ages_all, aclk, aresetn, proc && (p_mode_reg == MODE_TICK),
                 fresh_reg == '0)
    // Input is only held off while the input stage is occupied
    `ASSERT_SAME(a_ready_low, aclk, aresetn, !s_tready, p_valid_reg)
    // Repeat flag implies held; edges are exclusive
    `ASSERT_SAME(a_result_consistent, aclk, aresetn, m_valid_reg,
                 (!m_res_reg.pressed_repeated || m_res_reg.pressed) &&
                 !(m_res_reg.pressed_edge && m_res_reg.released_edge))

endmodule

`default_nettype wire

// ----- verif/key_press_edge_tracker_checker.sv -----
// Checker for the key press edge tracker: tracks key status, predicts result beats, compares.
`timescale 1ns / 1ps

module key_press_edge_tracker_checker #(
    parameter int KEYS = kpet_pkg::KEYS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [kpet_pkg::SDATA_W-1:0] s_tdata,
    input  logic [kpet_pkg::MODE_W-1:0]  s_tuser,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [kpet_pkg::MDATA_W-1:0] m_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    output int                           errors,
    output int                           outstanding
);
    import kpet_pkg::*;

    localparam int RES_W = $bits(result_t);

    // Shadow copy of every key's status word
    status_t key_state [2**KEY_W];
    // Flags still owed by the block, oldest first
    result_t flags_due [$];

    int mismatches = 0;
    int due_count  = 0;

    assign errors      = mismatches;
    assign outstanding = due_count;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Apply one input beat to the shadow status and return the named key's flags
    function automatic result_t apply_key_item(input mode_t kind, input logic [KEY_W-1:0] key);
        status_t s;
        result_t r;
        if (kind == MODE_TICK) begin
            for (int i = 0; i < 2**KEY_W; i++) begin
                key_state[i].held_prev = key_state[i].held;
                key_state[i].event_now = 1'b0;
            end
        end else if (key < KEYS) begin
            if (kind == MODE_PRESS) begin
                key_state[key].held      = 1'b1;
                key_state[key].event_now = 1'b1;
            end else if (kind == MODE_RELEASE) begin
                key_state[key].held      = 1'b0;
                key_state[key].event_now = 1'b1;
            end
        end
        // out-of-range keys report all flags low
        s = (key < KEYS) ? key_state[key] : '0;
        r.pressed          = s.held;
        r.pressed_edge     = s.held && !s.held_prev;
        r.pressed_repeated = s.held && s.event_now;
        r.released_edge    = !s.held && s.held_prev;
        return r;
    endfunction

    // Predict on input beats, compare on result beats
    always @(posedge aclk) begin : track
        result_t want;
        result_t got;
        if (!aresetn) begin
            for (int i = 0; i < 2**KEY_W; i++) key_state[i] = '0;
            flags_due.delete();
            due_count <= 0;
        end else begin
            if (s_tvalid && s_tready)
                flags_due.push_back(apply_key_item(mode_t'(s_tuser), s_tdata[KEY_W-1:0]));
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[RES_W-1:0]);
                if (flags_due.size() == 0) begin
                    report_mismatch("result beat with nothing pending", m_tdata, 0);
                end else begin
                    want = flags_due.pop_front();
                    if (got.pressed !== want.pressed)
                        report_mismatch("pressed", got.pressed, want.pressed);
                    if (got.pressed_edge !== want.pressed_edge)
                        report_mismatch("pressed_edge", got.pressed_edge, want.pressed_edge);
                    if (got.pressed_repeated !== want.pressed_repeated)
                        report_mismatch("pressed_repeated", got.pressed_repeated,
                                        want.pressed_repeated);
                    if (got.released_edge !== want.released_edge)
                        report_mismatch("released_edge", got.released_edge, want.released_edge);
                    if (m_tdata[MDATA_W-1:RES_W] !== '0)
                        report_mismatch("m_tdata padding", m_tdata[MDATA_W-1:RES_W], 0);
                end
            end
            due_count <= flags_due.size();
        end
    end

endmodule

// ----- verif/key_press_edge_tracker_core_tb.sv -----
// Testbench top for the key press edge tracker: clock, reset, stimulus, back-pressure, verdict.
`timescale 1ns / 1ps

module key_press_edge_tracker_core_tb;
    import kpet_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RANDOM_ITEMS = 2000;
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off to fill the pipe
    localparam int STALL_LIMIT  = 5000;  // cycles with no beat on either side
    localparam int TAIL_CYCLES  = 8;     // settle time after the last result beat

    logic               aclk;
    logic               aresetn;
    logic [SDATA_W-1:0] s_tdata;
    logic [MODE_W-1:0]  s_tuser;
    logic               s_tvalid;
    logic               s_tready;
    logic [MDATA_W-1:0] m_tdata;
    logic               m_tvalid;
    logic               m_tready;

    int   errors;
    int   outstanding;
    logic hold_req;
    int   idle_cycles = 0;
    int   burst_left  = 0;

    key_press_edge_tracker_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    key_press_edge_tracker_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Offer one beat and hold it until accepted
    task automatic send_key_beat(input mode_t kind, input logic [KEY_W-1:0] key);
        s_tuser  <= kind;
        s_tdata  <= {{(SDATA_W - KEY_W){1'b0}}, key};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Bursts of random length, random gaps in between; gap 0 keeps the stream dense
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic key_beat(input mode_t kind, input logic [KEY_W-1:0] key);
        send_key_beat(kind, key);
        pace_sender();
    endtask

    // Stimulus
    initial begin : stim
        logic [KEY_W-1:0] focus [8];
        logic [KEY_W-1:0] key;
        mode_t            kind;
        int               pick;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = MODE_QUERY;
        hold_req = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes of the key index, all kinds, edges, repeats, tick with key
        key_beat(MODE_QUERY,   7'd0);
        key_beat(MODE_PRESS,   7'd0);
        key_beat(MODE_QUERY,   7'd0);
        key_beat(MODE_TICK,    7'd0);
        key_beat(MODE_QUERY,   7'd0);
        key_beat(MODE_PRESS,   7'd0);
        key_beat(MODE_RELEASE, 7'd0);
        key_beat(MODE_TICK,    7'd127);
        key_beat(MODE_QUERY,   7'd0);
        key_beat(MODE_TICK,    7'd0);
        key_beat(MODE_PRESS,   7'd127);
        key_beat(MODE_PRESS,   7'd127);
        key_beat(MODE_TICK,    7'd127);
        key_beat(MODE_RELEASE, 7'd127);
        key_beat(MODE_RELEASE, 7'd127);
        key_beat(MODE_QUERY,   7'd127);
        key_beat(MODE_PRESS,   7'd85);
        key_beat(MODE_TICK,    7'd42);
        key_beat(MODE_RELEASE, 7'd42);
        key_beat(MODE_QUERY,   7'd85);
        key_beat(MODE_TICK,    7'd85);
        key_beat(MODE_QUERY,   7'd42);

        // random: mostly a small pool of keys so press/tick/release sequences build up
        for (int i = 0; i < 8; i++) focus[i] = KEY_W'($urandom_range(0, 127));
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 4) hold_req <= 1'b1;
            if (n % 250 == 249) focus[$urandom_range(0, 7)] = KEY_W'($urandom_range(0, 127));
            pick = $urandom_range(0, 99);
            if (pick < 20)      kind = MODE_TICK;
            else if (pick < 45) kind = MODE_PRESS;
            else if (pick < 70) kind = MODE_RELEASE;
            else                kind = MODE_QUERY;
            key = ($urandom_range(0, 9) < 7) ? focus[$urandom_range(0, 7)]
                                             : KEY_W'($urandom_range(0, 127));
            key_beat(kind, key);
        end
        s_tvalid <= 1'b0;

        // drain; wait for the checker to count the last accepted beat first
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Receiver: stall pattern changes every stretch; one long hold-off on request
    initial begin : sink
        int  pattern;
        int  span;
        bit  hold_done;
        m_tready  = 1'b0;
        hold_done = 1'b0;
        forever begin
            pattern = $urandom_range(0, 3);
            span    = $urandom_range(20, 200);
            repeat (span) begin
                @(posedge aclk);
                if (hold_req && !hold_done) begin
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                    hold_done = 1'b1;
                end
                case (pattern)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Watchdog: too long without any beat on either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/kpet_pkg.sv
hdl/key_press_edge_tracker_core.sv
verif/key_press_edge_tracker_checker.sv
verif/key_press_edge_tracker_core_tb.sv
